>>> rtl/hlc_pkg.sv
package hlc_pkg;

    localparam int DATA_W = 64;
    localparam int LOGICAL_BITS_DEF = 18;
    localparam logic [DATA_W-1:0] MAX_OFFSET_RESET = 64'd16000000000;

    localparam logic OP_LOCAL = 1'b0;
    localparam logic OP_RECV  = 1'b1;

    typedef struct packed {
        logic [DATA_W-1:0] new_stamp;
        logic [DATA_W-1:0] lead_offset;
        logic              sync_error;
    } t_result;

endpackage

>>> rtl/hlc_req_if.sv
interface hlc_req_if;

    logic                       valid;
    logic                       ready;
    logic                       operation;
    logic [hlc_pkg::DATA_W-1:0] phys_time;
    logic [hlc_pkg::DATA_W-1:0] msg_stamp;

    modport source (output valid, output operation, output phys_time, output msg_stamp,
                    input ready);
    modport sink   (input valid, input operation, input phys_time, input msg_stamp,
                    output ready);

endinterface

>>> rtl/hlc_rsp_if.sv
interface hlc_rsp_if;

    logic                       valid;
    logic                       ready;
    logic [hlc_pkg::DATA_W-1:0] new_stamp;
    logic [hlc_pkg::DATA_W-1:0] lead_offset;
    logic                       sync_error;

    modport source (output valid, output new_stamp, output lead_offset, output sync_error,
                    input ready);
    modport sink   (input valid, input new_stamp, input lead_offset, input sync_error,
                    output ready);

endinterface

>>> rtl/hybrid_logical_clock_update.sv
// An accepted input transaction is held in the input register, then passes through
// the merge logic into the result register, which presents the result transaction.
// Throughput: one transaction per cycle while the result side is not stalled; the clock
// register is updated, unless the result is a sync error, in the same cycle the result
// register loads, so the next transaction sees it at once. Reset (synchronous, active
// low) clears both stage valids, sets the clock to zero and max_offset to 16000000000.
module hybrid_logical_clock_update #(
    parameter int LOGICAL_BITS = hlc_pkg::LOGICAL_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [hlc_pkg::DATA_W-1:0] i_cfg_wdata,
    hlc_req_if.sink                    i_req,
    hlc_rsp_if.source                  o_rsp
);

    localparam int W = hlc_pkg::DATA_W;

    logic             r_in_valid;
    logic             r_in_op;
    logic [W-1:0]     r_in_phys;
    logic [W-1:0]     r_in_msg;
    logic             r_out_valid;
    hlc_pkg::t_result r_out;
    logic [W-1:0]     r_clock;
    logic [W-1:0]     r_max_offset;

    hlc_pkg::t_result n_out;
    logic             clock_we;
    logic             advance;

    assign advance     = r_in_valid && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = !r_in_valid || advance;

    hlc_merge #(
        .LOGICAL_BITS (LOGICAL_BITS)
    ) u_merge (
        .i_operation  (r_in_op),
        .i_phys_time  (r_in_phys),
        .i_msg_stamp  (r_in_msg),
        .i_clock      (r_clock),
        .i_max_offset (r_max_offset),
        .o_result     (n_out),
        .o_clock_we   (clock_we)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_clock      <= '0;
            r_max_offset <= hlc_pkg::MAX_OFFSET_RESET;
        end else begin
            if (i_req.ready) begin
                r_in_valid <= i_req.valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            if (advance && clock_we) begin
                r_clock <= n_out.new_stamp;
            end
            if (i_cfg_we) begin
                r_max_offset <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_in_op   <= i_req.operation;
            r_in_phys <= i_req.phys_time;
            r_in_msg  <= i_req.msg_stamp;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.new_stamp   = r_out.new_stamp;
    assign o_rsp.lead_offset = r_out.lead_offset;
    assign o_rsp.sync_error  = r_out.sync_error;

endmodule

>>> rtl/hlc_merge.sv
module hlc_merge #(
    parameter int LOGICAL_BITS = hlc_pkg::LOGICAL_BITS_DEF
) (
    input  logic                       i_operation,
    input  logic [hlc_pkg::DATA_W-1:0] i_phys_time,
    input  logic [hlc_pkg::DATA_W-1:0] i_msg_stamp,
    input  logic [hlc_pkg::DATA_W-1:0] i_clock,
    input  logic [hlc_pkg::DATA_W-1:0] i_max_offset,
    output hlc_pkg::t_result           o_result,
    output logic                       o_clock_we
);

    localparam int W = hlc_pkg::DATA_W;
    localparam logic [W-1:0] LOW_MASK = {{(W-LOGICAL_BITS){1'b0}}, {LOGICAL_BITS{1'b1}}};

    logic [W-1:0] pt;
    logic [W-1:0] ml;
    logic [W-1:0] cp;
    logic [W-1:0] lead;
    logic [W-1:0] clock_inc;
    logic [W-1:0] msg_inc;
    logic [W-1:0] max_inc;
    logic [W-1:0] next_clock;
    logic         err;

    assign pt        = i_phys_time & ~LOW_MASK;
    assign ml        = i_msg_stamp & ~LOW_MASK;
    assign cp        = i_clock & ~LOW_MASK;
    assign clock_inc = i_clock + W'(1);
    assign msg_inc   = i_msg_stamp + W'(1);
    assign max_inc   = (i_clock < i_msg_stamp) ? msg_inc : clock_inc;
    assign lead      = (ml > pt) ? (ml - pt) : '0;
    assign err       = (i_operation == hlc_pkg::OP_RECV) && (lead > i_max_offset);

    always_comb begin
        next_clock = clock_inc;
        unique case (i_operation)
            hlc_pkg::OP_LOCAL: begin
                next_clock = (cp < pt) ? pt : clock_inc;
            end
            hlc_pkg::OP_RECV: begin
                priority if (cp < ml) begin
                    next_clock = (ml < pt) ? pt : msg_inc;
                end else if (cp < pt) begin
                    next_clock = pt;
                end else if (pt <= ml) begin
                    next_clock = max_inc;
                end else begin
                    next_clock = clock_inc;
                end
            end
            default: begin
                next_clock = clock_inc;
            end
        endcase
    end

    always_comb begin
        o_result.new_stamp   = err ? '0 : next_clock;
        o_result.lead_offset = (i_operation == hlc_pkg::OP_RECV) ? lead : '0;
        o_result.sync_error  = err;
    end

    assign o_clock_we = !err;

endmodule

>>> rtl/hlc_checker.sv
module hlc_checker #(
    parameter int LOGICAL_BITS = hlc_pkg::LOGICAL_BITS_DEF
) (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_rsp_valid,
    input logic                       i_rsp_ready,
    input logic [hlc_pkg::DATA_W-1:0] i_new_stamp,
    input logic [hlc_pkg::DATA_W-1:0] i_lead_offset,
    input logic                       i_sync_error
);

    localparam int W = hlc_pkg::DATA_W;
    localparam logic [W-1:0] LOW_MASK = {{(W-LOGICAL_BITS){1'b0}}, {LOGICAL_BITS{1'b1}}};

    // A sync error leaves the clock alone and reports a zero stamp.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && i_sync_error) |-> (i_new_stamp == '0))
    else $error("sync error with nonzero new_stamp");

    // A sync error needs a lead beyond max_offset, so the lead cannot be zero.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && i_sync_error) |-> (i_lead_offset != '0))
    else $error("sync error with zero lead_offset");

    // The lead is a difference of two physical parts.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> ((i_lead_offset & LOW_MASK) == '0))
    else $error("lead_offset has logical bits set");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=>
        (i_rsp_valid && $stable(i_new_stamp) && $stable(i_lead_offset)
         && $stable(i_sync_error)))
    else $error("stalled result transaction changed");

    assert property (@(posedge i_clk) !i_rst_n |=> !i_rsp_valid)
    else $error("result valid right after reset");

endmodule

bind hybrid_logical_clock_update hlc_checker #(
    .LOGICAL_BITS (LOGICAL_BITS)
) u_hlc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_rsp_valid   (o_rsp.valid),
    .i_rsp_ready   (o_rsp.ready),
    .i_new_stamp   (o_rsp.new_stamp),
    .i_lead_offset (o_rsp.lead_offset),
    .i_sync_error  (o_rsp.sync_error)
);

>>> sim/hybrid_logical_clock_update_checker.sv
`timescale 1ns / 1ps

module hybrid_logical_clock_update_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [hlc_pkg::DATA_W-1:0] i_cfg_wdata,
    hlc_req_if                         i_req,
    hlc_rsp_if                         i_rsp,
    output int                         o_fail_count,
    output int                         o_pending
);

    localparam int W = hlc_pkg::DATA_W;
    localparam logic [W-1:0] LOGIC_MASK = (64'd1 << hlc_pkg::LOGICAL_BITS_DEF) - 64'd1;

    logic [W-1:0]     hlc_clock = '0;
    logic [W-1:0]     lead_limit = hlc_pkg::MAX_OFFSET_RESET;
    hlc_pkg::t_result stamp_queue[$];
    int               fail_count = 0;
    int               pending_count = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending_count;

    function automatic logic [W-1:0] phys_of(input logic [W-1:0] value);
        return value & ~LOGIC_MASK;
    endfunction

    function automatic hlc_pkg::t_result advance_clock(input logic op,
                                                       input logic [W-1:0] phys,
                                                       input logic [W-1:0] msg);
        hlc_pkg::t_result res;
        logic [W-1:0]     pt;
        logic [W-1:0]     cp;
        logic [W-1:0]     ml;
        logic [W-1:0]     nxt;
        res = '0;
        pt  = phys_of(phys);
        cp  = phys_of(hlc_clock);
        if (op == hlc_pkg::OP_LOCAL) begin
            nxt = (cp < pt) ? pt : hlc_clock + 64'd1;
            hlc_clock = nxt;
            res.new_stamp = nxt;
        end else begin
            ml = phys_of(msg);
            res.lead_offset = (ml > pt) ? ml - pt : '0;
            if (res.lead_offset > lead_limit) begin
                res.sync_error = 1'b1;
            end else begin
                if (cp < ml) begin
                    nxt = (ml < pt) ? pt : msg + 64'd1;
                end else if (cp < pt) begin
                    nxt = pt;
                end else if (pt <= ml) begin
                    nxt = ((hlc_clock < msg) ? msg : hlc_clock) + 64'd1;
                end else begin
                    nxt = hlc_clock + 64'd1;
                end
                hlc_clock = nxt;
                res.new_stamp = nxt;
            end
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        hlc_pkg::t_result want;
        if (!i_rst_n) begin
            hlc_clock  = '0;
            lead_limit = hlc_pkg::MAX_OFFSET_RESET;
            stamp_queue.delete();
        end else begin
            if (i_cfg_we) begin
                lead_limit = i_cfg_wdata;
            end
            if (i_rsp.valid && i_rsp.ready) begin
                if (stamp_queue.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("%0t: result transaction with no expectation:", $realtime);
                        $display("%0t:           actual   stamp %h lead %h err %b",
                                 $realtime, i_rsp.new_stamp, i_rsp.lead_offset,
                                 i_rsp.sync_error);
                    end
                end else begin
                    want = stamp_queue.pop_front();
                    if (want.new_stamp !== i_rsp.new_stamp ||
                        want.lead_offset !== i_rsp.lead_offset ||
                        want.sync_error !== i_rsp.sync_error) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display("%0t: mismatch: expected stamp %h lead %h err %b",
                                     $realtime, want.new_stamp, want.lead_offset,
                                     want.sync_error);
                            $display("%0t:           actual   stamp %h lead %h err %b",
                                     $realtime, i_rsp.new_stamp, i_rsp.lead_offset,
                                     i_rsp.sync_error);
                        end
                    end
                end
            end
            if (i_req.valid && i_req.ready) begin
                stamp_queue.push_back(advance_clock(i_req.operation, i_req.phys_time,
                                                    i_req.msg_stamp));
            end
        end
        pending_count = stamp_queue.size();
    end

endmodule

>>> sim/hybrid_logical_clock_update_tb.sv
`timescale 1ns / 1ps

module hybrid_logical_clock_update_tb;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} t_idle_mode;

    localparam int           W           = hlc_pkg::DATA_W;
    localparam int           LB          = hlc_pkg::LOGICAL_BITS_DEF;
    localparam logic [W-1:0] LOGIC_MASK  = (64'd1 << LB) - 64'd1;
    localparam logic [W-1:0] ALL_ONES    = {W{1'b1}};
    localparam int           NUM_PHASES  = 6;
    localparam int           PHASE_ITEMS = 88;
    localparam int           HOLD_CYCLES = 300;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_cfg_we;
    logic [W-1:0] i_cfg_wdata;

    hlc_req_if req_if ();
    hlc_rsp_if rsp_if ();

    int           chk_fail_count;
    int           chk_pending;
    t_idle_mode   idle_mode = IDLE_NONE;
    logic         hold_req = 1'b0;
    logic [W-1:0] wall_time;

    hybrid_logical_clock_update i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_req      (req_if),
        .o_rsp      (rsp_if)
    );

    hybrid_logical_clock_update_checker i_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (req_if),
        .i_rsp       (rsp_if),
        .o_fail_count(chk_fail_count),
        .o_pending   (chk_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("hybrid_logical_clock_update_tb: done, errors");
        $finish;
    end

    function automatic logic [W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [W-1:0] rand_logical();
        return ($urandom_range(3) == 0) ? LOGIC_MASK : 64'($urandom_range(32'h3FFFF));
    endfunction

    initial begin
        logic hold_ack;
        int   hold_left;
        int   stall_pct;
        hold_ack  = 1'b0;
        hold_left = 0;
        rsp_if.ready <= 1'b0;
        forever begin
            @(negedge i_clk);
            stall_pct = (idle_mode == IDLE_RECV) ? 62 : (idle_mode == IDLE_BOTH) ? 35 : 0;
            if (hold_left > 0) begin
                hold_left--;
                rsp_if.ready <= 1'b0;
            end else if (hold_req != hold_ack) begin
                hold_ack  = hold_req;
                hold_left = HOLD_CYCLES - 1;
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= !(stall_pct > 0 && $urandom_range(99) < stall_pct);
            end
        end
    end

    task automatic send_item(input logic op, input logic [W-1:0] phys,
                             input logic [W-1:0] msg);
        int gap_pct;
        gap_pct = (idle_mode == IDLE_SEND) ? 62 : (idle_mode == IDLE_BOTH) ? 35 : 0;
        while (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
            req_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_if.valid     <= 1'b1;
        req_if.operation <= op;
        req_if.phys_time <= phys;
        req_if.msg_stamp <= msg;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        req_if.valid <= 1'b0;
        while (chk_pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_max_offset(input logic [W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic send_random(input logic [W-1:0] limit);
        logic [W-1:0] pt;
        logic [W-1:0] lead;
        logic [W-1:0] lim_al;
        int           pick;
        pick = $urandom_range(99);
        if (pick < 10) begin
            send_item(1'($urandom_range(1)), rand64(), rand64());
        end else begin
            if ($urandom_range(3) != 0) begin
                wall_time = wall_time + (64'($urandom_range(1, 4)) << LB);
            end
            if ($urandom_range(19) == 0) begin
                wall_time = wall_time - (64'd8 << LB);
            end
            pt = (wall_time & ~LOGIC_MASK) | rand_logical();
            if (pick < 40) begin
                send_item(hlc_pkg::OP_LOCAL, pt, rand64());
            end else begin
                lim_al = limit & ~LOGIC_MASK;
                case ($urandom_range(5))
                    0: begin
                        lead = lim_al;
                    end
                    1: begin
                        lead = lim_al + (64'd1 << LB);
                    end
                    2: begin
                        lead = rand64() >> $urandom_range(63);
                    end
                    3: begin
                        lead = '0;
                    end
                    4: begin
                        lead = -(64'($urandom_range(1, 64)) << LB);
                    end
                    default: begin
                        lead = 64'($urandom_range(0, 16)) << LB;
                    end
                endcase
                send_item(hlc_pkg::OP_RECV, pt,
                          (((wall_time & ~LOGIC_MASK) + lead) & ~LOGIC_MASK) | rand_logical());
            end
        end
    endtask

    initial begin
        logic [W-1:0] phase_limit [NUM_PHASES];
        t_idle_mode   phase_mode [NUM_PHASES];
        logic [W-1:0] lim_al;
        logic [W-1:0] base;
        int           waited;

        i_rst_n          <= 1'b0;
        i_cfg_we         <= 1'b0;
        i_cfg_wdata      <= '0;
        req_if.valid     <= 1'b0;
        req_if.operation <= hlc_pkg::OP_LOCAL;
        req_if.phys_time <= '0;
        req_if.msg_stamp <= '0;

        phase_limit[0] = '0;
        phase_limit[1] = ALL_ONES;
        phase_limit[2] = 64'd1 << 30;
        phase_limit[3] = rand64() >> $urandom_range(8, 30);
        phase_limit[4] = hlc_pkg::MAX_OFFSET_RESET;
        phase_limit[5] = 64'd1 << LB;
        phase_mode[0]  = IDLE_NONE;
        phase_mode[1]  = IDLE_SEND;
        phase_mode[2]  = IDLE_RECV;
        phase_mode[3]  = IDLE_BOTH;
        phase_mode[4]  = IDLE_NONE;
        phase_mode[5]  = IDLE_RECV;

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        lim_al = hlc_pkg::MAX_OFFSET_RESET & ~LOGIC_MASK;
        base   = 64'h0000_1000_0000_0000;
        send_item(hlc_pkg::OP_LOCAL, '0, '0);
        send_item(hlc_pkg::OP_LOCAL, (64'd5 << 18) | 64'h123, '0);
        send_item(hlc_pkg::OP_LOCAL, 64'd5 << 18, '0);
        send_item(hlc_pkg::OP_LOCAL, 64'd3 << 18, '0);
        send_item(hlc_pkg::OP_RECV, 64'd5 << 18, (64'd5 << 18) | 64'h3FFF0);
        send_item(hlc_pkg::OP_RECV, 64'd5 << 18, (64'd9 << 18) | 64'd7);
        send_item(hlc_pkg::OP_RECV, 64'd20 << 18, 64'd2 << 18);
        send_item(hlc_pkg::OP_RECV, 64'd40 << 18, (64'd30 << 18) | 64'd5);
        send_item(hlc_pkg::OP_RECV, 64'd10 << 18, 64'd1 << 18);
        send_item(hlc_pkg::OP_RECV, '0, ALL_ONES);
        send_item(hlc_pkg::OP_RECV, base, base + lim_al);
        send_item(hlc_pkg::OP_RECV, base, base + lim_al + (64'd1 << 18));
        send_item(hlc_pkg::OP_RECV, ALL_ONES, ALL_ONES);
        send_item(hlc_pkg::OP_LOCAL, '0, '0);
        send_item(hlc_pkg::OP_RECV, 64'h0000_0001_0000_0000, 64'h0000_0001_0003_FFFF);
        send_item(hlc_pkg::OP_LOCAL, '0, '0);
        send_item(hlc_pkg::OP_LOCAL, ALL_ONES, '0);
        send_item(hlc_pkg::OP_RECV, '0, ALL_ONES);
        send_item(hlc_pkg::OP_RECV, ALL_ONES, ALL_ONES);
        send_item(hlc_pkg::OP_RECV, '0, '0);
        send_item(hlc_pkg::OP_LOCAL, '0, ALL_ONES);

        for (int p = 0; p < NUM_PHASES; p++) begin
            drain_results();
            write_max_offset(phase_limit[p]);
            idle_mode = phase_mode[p];
            wall_time = rand64();
            if (p == 0) begin
                hold_req = ~hold_req;
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_random(phase_limit[p]);
            end
        end

        req_if.valid <= 1'b0;
        waited = 0;
        while (chk_pending != 0 && waited < 5000) begin
            @(negedge i_clk);
            waited++;
        end
        repeat (8) @(negedge i_clk);
        if (chk_fail_count == 0 && chk_pending == 0) begin
            $display("hybrid_logical_clock_update_tb: done, clean");
        end else begin
            $display("hybrid_logical_clock_update_tb: done, errors");
        end
        $finish;
    end

endmodule
